/* rtl/radix_digit_formatter_top_macros.svh */
// Assertion macros shared by the radix digit formatter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RADIX_DIGIT_FORMATTER_TOP_MACROS_SVH
`define RADIX_DIGIT_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

/* rtl/rdf_pkg.sv */
// Package for the radix digit formatter: widths, register codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package rdf_pkg;

  localparam int NUM_W          = 64;
  localparam int CHAR_W         = 8;
  localparam int RADIX_W        = 6;
  localparam int SYMBOL_REGS    = 7;
  localparam int SYM_REG_W      = 64;
  localparam int MAX_SYMBOLS    = 56;
  localparam int MAX_DIGITS_DEF = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int BASE_RESET     = 2;

  // Quotient bits resolved per cycle by the restoring divider.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SIZE = 3'd0,
    REG_SYM_0_7   = 3'd1,
    REG_SYM_8_15  = 3'd2,
    REG_SYM_16_23 = 3'd3,
    REG_SYM_24_31 = 3'd4,
    REG_SYM_32_39 = 3'd5,
    REG_SYM_40_47 = 3'd6,
    REG_SYM_48_55 = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_FETCH,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store_digit;
    logic fetch;
    logic load_out;
    logic ptr_dec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic more_digits;
    logic out_free;
    logic ptr_zero;
  } ctrl_status_t;

endpackage

/* rtl/rdf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the digit store of the radix digit formatter.
module rdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rdf_ctrl.sv */
// Sequencer of the radix digit formatter: divide, store, fetch and emit steps.
// Depends on rdf_pkg for states and the command/status structs.
module rdf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rdf_pkg::ctrl_status_t status_i,
  output rdf_pkg::ctrl_cmd_t    cmd_o
);
  import rdf_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_q == STEP_LAST) state_d = ST_STORE;
      end
      ST_STORE: begin
        state_d = status_i.more_digits ? ST_DIVIDE : ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) state_d = status_i.ptr_zero ? ST_IDLE : ST_FETCH;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The step counter wraps to zero after the last slice of each digit.
  always_comb begin
    step_d = step_q;
    if (state_q == ST_DIVIDE) begin
      step_d = step_q + STEP_W'(1);
    end else begin
      step_d = '0;
    end
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIVIDE: cmd_o.div_step    = 1'b1;
      ST_STORE:  cmd_o.store_digit = 1'b1;
      ST_FETCH:  cmd_o.fetch       = 1'b1;
      ST_LOAD: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.ptr_dec  = status_i.out_free && !status_i.ptr_zero;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/rdf_datapath.sv */
// Datapath of the radix digit formatter: configuration registers, restoring
// divider, digit store, symbol lookup and output register. Uses rdf_pkg and rdf_ram.
module rdf_datapath #(
  parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rdf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rdf_pkg::SYM_REG_W-1:0] cfg_data_i,
  input  logic [rdf_pkg::NUM_W-1:0]     number_i,
  input  rdf_pkg::ctrl_cmd_t            cmd_i,
  output rdf_pkg::ctrl_status_t         status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rdf_pkg::CHAR_W-1:0]    out_char_o,
  output logic                          out_last_o
);
  import rdf_pkg::*;

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [RADIX_W-1:0]   base_size_q;
  logic [SYM_REG_W-1:0] sym_q [SYMBOL_REGS];
  logic [RADIX_W-1:0]   radix;

  logic [NUM_W-1:0]   quot_q, quot_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [RADIX_W-1:0] digit_rd;

  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;
  logic              out_valid_q, out_valid_d;

  logic [NUM_W-1:0]   step_quot;
  logic [RADIX_W-1:0] step_rem;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q <= RADIX_W'(BASE_RESET);
      for (int i = 0; i < SYMBOL_REGS; i++) begin
        sym_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE_SIZE: base_size_q <= cfg_data_i[RADIX_W-1:0];
        REG_SYM_0_7:   sym_q[0] <= cfg_data_i;
        REG_SYM_8_15:  sym_q[1] <= cfg_data_i;
        REG_SYM_16_23: sym_q[2] <= cfg_data_i;
        REG_SYM_24_31: sym_q[3] <= cfg_data_i;
        REG_SYM_32_39: sym_q[4] <= cfg_data_i;
        REG_SYM_40_47: sym_q[5] <= cfg_data_i;
        REG_SYM_48_55: sym_q[6] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Radix in use: clamped into the range the symbol table supports.
  always_comb begin
    radix = base_size_q;
    if (base_size_q inside {RADIX_W'(0), RADIX_W'(1)}) begin
      radix = RADIX_W'(2);
    end else if (base_size_q > RADIX_W'(MAX_SYMBOLS)) begin
      radix = RADIX_W'(MAX_SYMBOLS);
    end
  end

  // One slice of restoring division: DIV_BITS quotient bits per cycle. The
  // partial remainder stays below the radix, so each trial is seven bits wide.
  always_comb begin
    logic [RADIX_W:0] trial;
    step_quot = quot_q;
    step_rem  = rem_q;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial     = {step_rem, step_quot[NUM_W-1]};
      step_quot = {step_quot[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, radix}) begin
        trial        = trial - {1'b0, radix};
        step_quot[0] = 1'b1;
      end
      step_rem = trial[RADIX_W-1:0];
    end
  end

  assign cnt_inc = cnt_q + CW'(1);

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    if (cmd_i.load) begin
      quot_d = number_i;
      rem_d  = '0;
      cnt_d  = '0;
    end
    if (cmd_i.div_step) begin
      quot_d = step_quot;
      rem_d  = step_rem;
    end
    if (cmd_i.store_digit) begin
      rem_d = '0;
      cnt_d = cnt_inc;
      ptr_d = cnt_q[AW-1:0];
    end
    if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      ptr_q  <= '0;
    end else begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      ptr_q  <= ptr_d;
    end
  end

  // Digits land least significant first and are read back from the top.
  rdf_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_digit),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rem_q),
    .re_i    (cmd_i.fetch),
    .raddr_i (ptr_q),
    .rdata_o (digit_rd)
  );

  // Symbol lookup: the register group wraps modulo the number of groups.
  function automatic logic [CHAR_W-1:0] symbol_of(
    input logic [SYM_REG_W-1:0] regs [SYMBOL_REGS],
    input logic [RADIX_W-1:0]   digit
  );
    logic [2:0]           grp;
    logic [SYM_REG_W-1:0] word;
    grp = digit[RADIX_W-1:3];
    if (grp == 3'(SYMBOL_REGS)) begin
      grp = '0;
    end
    word = regs[grp];
    return word[digit[2:0]*CHAR_W +: CHAR_W];
  endfunction

  // Output register; a new character loads only once the previous beat has left or is leaving.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_char_q <= symbol_of(sym_q, digit_rd);
      out_last_q <= (ptr_q == '0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.more_digits = (quot_q != '0) && (cnt_inc < CW'(MAX_DIGITS));
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.ptr_zero    = (ptr_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

`include "radix_digit_formatter_top_macros.svh"

  `RDF_ASSERT_IMP(a_load_needs_free_slot, clk_i, rst_ni, cmd_i.load_out, !out_valid_q || out_ready_i)
  `RDF_ASSERT_IMP(a_store_within_depth, clk_i, rst_ni, cmd_i.store_digit, cnt_q < CW'(MAX_DIGITS))
  `RDF_ASSERT_NXT(a_ptr_tracks_count, clk_i, rst_ni, cmd_i.store_digit, CW'(ptr_q) + CW'(1) == cnt_q)

endmodule

/* rtl/radix_digit_formatter_top.sv */
// Top level of the radix digit formatter: stream ports and configuration port.
// Instantiates rdf_ctrl and rdf_datapath; depends on rdf_pkg.

// Converts each accepted 64-bit unsigned number into its digits in the radix held
// in register 0 (values below 2 act as 2, above 56 as 56) and sends one beat per
// digit, most significant first, each beat carrying the symbol looked up in
// registers 1 to 7 and tlast on the final digit; zero gives one beat with the
// symbol of digit value 0. A number of d digits (1 <= d <= MAX_DIGITS; more
// significant digits beyond MAX_DIGITS are dropped) is done in two phases: the
// restoring divider, which resolves 8 quotient bits per cycle, produces all
// digits into the digit RAM; then each is read back through the RAM's registered
// port and loaded into the output register once the output slot is free. The
// next number is taken as soon as the final beat of the previous one sits in
// the output register. The configuration port is always ready and must only
// be written while the block is idle.
module radix_digit_formatter_top #(
  parameter int MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rdf_pkg::NUM_W-1:0]     s_axis_tdata,  // [63:0] number
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rdf_pkg::CHAR_W-1:0]    m_axis_tdata,  // [7:0] char_code
  output logic                          m_axis_tlast,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rdf_pkg::SYM_REG_W-1:0] cfg_data_i
);
  import rdf_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  rdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdf_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .number_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
